FILE: hdl/pause_event_overwrite_ring_defines.svh
// Assertion macros used by the checker of the pause event ring.
`ifndef PAUSE_EVENT_OVERWRITE_RING_DEFINES_SVH
`define PAUSE_EVENT_OVERWRITE_RING_DEFINES_SVH

// Same-cycle property, sampled on the rising clock, off during reset.
`define PEVR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle property, sampled on the rising clock, off during reset.
`define PEVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pevr_pkg.sv
package pevr_pkg;

  // Default sizes.
  localparam int unsigned RingDepthDef = 256;
  localparam int unsigned MaxDrainDef  = 64;

  // Field widths.
  localparam int unsigned TimeW  = 63;
  localparam int unsigned CountW = 63;
  localparam int unsigned GenW   = 8;
  localparam int unsigned DropW  = 64;

  // Record as stored in the ring, start time in the lowest bits.
  typedef struct packed {
    logic [GenW-1:0]   generation;
    logic [CountW-1:0] uncollectable;
    logic [CountW-1:0] collected;
    logic [TimeW-1:0]  duration;
    logic [TimeW-1:0]  start;
  } rec_t;

  localparam int unsigned RecW       = $bits(rec_t);
  localparam int unsigned InDataW    = 216;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 328;
  localparam int unsigned OutUserW   = 1;
  localparam int unsigned OutPadW    = OutDataW - RecW - DropW;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_DRAIN = 2'd2
  } req_e;

endpackage

FILE: hdl/pevr_ram.sv
module pevr_ram
  import pevr_pkg::*;
#(
  parameter int unsigned Depth = RingDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hdl/pevr_rec_build.sv
module pevr_rec_build
  import pevr_pkg::*;
(
  input  logic [TimeW-1:0] now_i,
  input  logic [TimeW-1:0] pending_i,
  input  logic [10:0]      generation_i,
  input  logic [63:0]      collected_i,
  input  logic [63:0]      uncollectable_i,
  output logic             gen_ok_o,
  output rec_t             rec_o
);

  // Only generations 0..255 make a record; the sign bit rules out -1.
  assign gen_ok_o = (generation_i[10:GenW] == '0);

  // Duration clamps to zero when time did not move forward; negative counts clamp to zero.
  always_comb begin
    rec_o.start         = pending_i;
    rec_o.duration      = (now_i > pending_i) ? (now_i - pending_i) : '0;
    rec_o.collected     = collected_i[63] ? '0 : collected_i[CountW-1:0];
    rec_o.uncollectable = uncollectable_i[63] ? '0 : uncollectable_i[CountW-1:0];
    rec_o.generation    = generation_i[GenW-1:0];
  end

endmodule

FILE: hdl/pause_event_overwrite_ring.sv
// Start and stop beats are accepted back to back.
// A drain beat is followed by its results, one record at a time: ST_RD reads the ring memory
// through its registered read port, then ST_LD loads the record once the output register is free.
// A drain that returns no record gives its single beat through ST_EMPTY and the output register.
// Input is held off until the last beat of a drain is loaded.
// Reset clears head, fill, drop count and pending start; the ring memory is not cleared.
module pause_event_overwrite_ring
  import pevr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef,
  parameter int unsigned MAX_DRAIN  = MaxDrainDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now_us[62:0], generation[73:63], collected[137:74], uncollectable[201:138],
  // drain_limit[208:202], zero fill above
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pause_start[62:0], pause_len[125:63], collected_out[188:126],
  // uncollectable_out[251:189], generation_out[259:252], dropped_count[323:260],
  // zero fill above
  output logic [OutDataW-1:0] m_axis_tdata,
  // has_event[0]
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SumW = PtrW + 2;
  localparam int unsigned DrnW = $clog2(MAX_DRAIN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_EMPTY
  } state_e;

  state_e           state_q;
  logic [PtrW-1:0]  head_q;
  logic [CntW-1:0]  fill_q;
  logic [DropW-1:0] drop_q;
  logic [DropW-1:0] snap_q;
  logic [TimeW-1:0] pending_q;
  logic [DrnW-1:0]  remain_q;
  logic             out_valid_q;
  logic             out_event_q;
  logic             out_last_q;
  rec_t             out_rec_q;
  logic [DropW-1:0] out_drop_q;

  // Input beat fields.
  logic [TimeW-1:0] now;
  logic [10:0]      gen_in;
  logic [63:0]      col_in;
  logic [63:0]      unc_in;
  logic [6:0]       limit_in;
  req_e             req;

  assign now      = s_axis_tdata[62:0];
  assign gen_in   = s_axis_tdata[73:63];
  assign col_in   = s_axis_tdata[137:74];
  assign unc_in   = s_axis_tdata[201:138];
  assign limit_in = s_axis_tdata[208:202];
  assign req      = req_e'(s_axis_tuser);

  logic s_fire;
  logic out_free;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // A result beat is loaded when the output register is free in a loading state.
  logic out_load;
  assign out_load = out_free && ((state_q == ST_EMPTY) || (state_q == ST_LD));

  // Drain limit saturates at the largest drain.
  logic [DrnW-1:0] limit_sat;
  assign limit_sat = (limit_in > 7'(MAX_DRAIN)) ? DrnW'(MAX_DRAIN) : DrnW'(limit_in);

  // Next head position, wrapping at the ring depth.
  logic [PtrW-1:0] head_inc;
  assign head_inc = (head_q == PtrW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // Write slot is head plus fill, wrapped; when full this lands on the oldest entry.
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic            full;
  assign tail_sum = SumW'(head_q) + SumW'(fill_q);
  assign tail     = (tail_sum >= SumW'(RING_DEPTH)) ? PtrW'(tail_sum - SumW'(RING_DEPTH))
                                                    : PtrW'(tail_sum);
  assign full     = (fill_q == CntW'(RING_DEPTH));

  // Record build for a stop beat.
  logic gen_ok;
  rec_t new_rec;

  pevr_rec_build u_rec_build (
    .now_i          (now),
    .pending_i      (pending_q),
    .generation_i   (gen_in),
    .collected_i    (col_in),
    .uncollectable_i(unc_in),
    .gen_ok_o       (gen_ok),
    .rec_o          (new_rec)
  );

  // Ring memory; writes happen only in idle, reads only while draining, so they never meet.
  logic ram_we;
  logic ram_re;
  rec_t ram_rdata;
  assign ram_we = s_fire && (req == REQ_STOP) && gen_ok;
  assign ram_re = (state_q == ST_RD);

  pevr_ram #(
    .Depth(RING_DEPTH),
    .AddrW(PtrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail),
    .wdata_i(new_rec),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // The record being loaded is the last when the limit or the ring runs out.
  logic ld_last;
  assign ld_last = (remain_q == DrnW'(1)) || (fill_q == CntW'(1));

  // Control state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      drop_q      <= '0;
      snap_q      <= '0;
      pending_q   <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_event_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_rec_q   <= '0;
      out_drop_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            case (req)
              REQ_START: begin
                pending_q <= now;
              end
              REQ_STOP: begin
                if (gen_ok) begin
                  if (full) begin
                    head_q <= head_inc;
                    drop_q <= drop_q + 1'b1;
                  end else begin
                    fill_q <= fill_q + 1'b1;
                  end
                end
              end
              REQ_DRAIN: begin
                if (limit_sat == '0) begin
                  snap_q  <= '0;
                  state_q <= ST_EMPTY;
                end else begin
                  snap_q   <= drop_q;
                  drop_q   <= '0;
                  remain_q <= limit_sat;
                  state_q  <= (fill_q == '0) ? ST_EMPTY : ST_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            out_event_q <= 1'b0;
            out_last_q  <= 1'b1;
            out_rec_q   <= '0;
            out_drop_q  <= snap_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_RD: begin
          state_q <= ST_LD;
        end
        ST_LD: begin
          if (out_free) begin
            out_event_q <= 1'b1;
            out_last_q  <= ld_last;
            out_rec_q   <= ram_rdata;
            out_drop_q  <= ld_last ? snap_q : '0;
            head_q      <= head_inc;
            fill_q      <= fill_q - 1'b1;
            remain_q    <= remain_q - 1'b1;
            state_q     <= ld_last ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_drop_q, out_rec_q};
  assign m_axis_tuser  = out_event_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/pevr_checker.sv
`include "pause_event_overwrite_ring_defines.svh"

module pevr_checker
  import pevr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic [InUserW-1:0]  s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser,
  input logic                m_axis_tlast
);

  // A stalled result beat holds its contents.
  `PEVR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

  // While a drain is still in progress no new request is taken.
  `PEVR_ASSERT(a_drain_blocks_input, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during a drain")

  // Only the final beat of a drain may come without a record.
  `PEVR_ASSERT(a_mid_has_event, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0] && (m_axis_tdata[OutDataW-1:RecW] == '0), "middle drain beat without a record or with a drop count")

  // A beat without a record is a final beat with all record fields zero.
  `PEVR_ASSERT(a_empty_beat, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[RecW-1:0] == '0), "empty beat not final or not cleared")

endmodule

bind pause_event_overwrite_ring pevr_checker u_pevr_checker (.*);
